/* rtl/apbp_pkg.sv */
// ----------------------------------------------------------------------------
// apbp_pkg
// Shared types and constants for the alpha pixel bit packer.
// ----------------------------------------------------------------------------
package apbp_pkg;

    localparam int PIX_W = 8;
    localparam int FMT_W = 3;
    localparam int CNT_W = 3;

    // Pixel format codes. Codes 5 to 7 carry no meaning and behave as 8 bpp.
    typedef enum logic [FMT_W-1:0] {
        FMT_8BPP = 3'd0,
        FMT_4BPP = 3'd1,
        FMT_3BPP = 3'd2,
        FMT_2BPP = 3'd3,
        FMT_1BPP = 3'd4
    } t_fmt;

    localparam logic [PIX_W-1:0] MASK_TOP4 = 8'hF0;
    localparam logic [PIX_W-1:0] MASK_TOP3 = 8'hE0;
    localparam logic [PIX_W-1:0] MASK_TOP2 = 8'hC0;
    localparam logic [PIX_W-1:0] MASK_TOP1 = 8'h80;

endpackage

/* rtl/alpha_pixel_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// alpha_pixel_bit_packer_unit
// An accepted item waits in the input register; the byte it makes, if any, is
// then registered in the output register and shown on o_valid.
// Throughput: one item per cycle while the sink does not stall, set by the
// accumulator update between the input register and the output register.
// Reset (i_rst_n low, synchronous) empties both stages, clears the
// accumulator and fill count, and sets the format to 8 bits per pixel.
// ----------------------------------------------------------------------------
module alpha_pixel_bit_packer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: the pixel format register.
    input  logic                        i_cfg_we,
    input  logic [apbp_pkg::FMT_W-1:0]  i_cfg_wdata,
    // Input channel.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [apbp_pkg::PIX_W-1:0]  i_pixel,
    input  logic                        i_row_end,
    // Output channel.
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [apbp_pkg::PIX_W-1:0]  o_packed_byte,
    output logic                        o_last_of_row
);
    import apbp_pkg::*;

    // Configuration register.
    logic [FMT_W-1:0] r_fmt;

    // Input stage: the accepted item waits here for the packing logic.
    logic             r_in_vld;
    logic [PIX_W-1:0] r_in_pixel;
    logic             r_in_row_end;

    // Packing state carried from item to item within a row.
    logic [PIX_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [PIX_W-1:0] n_acc;
    logic [CNT_W-1:0] n_cnt;

    // Output register.
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_byte;
    logic             r_out_last;

    // Packing datapath signals.
    logic             move;
    logic             emit;
    logic             final_slot;
    logic [CNT_W-1:0] last_slot;
    logic [PIX_W-1:0] acc_base;
    logic [PIX_W-1:0] mid_bits;
    logic [PIX_W-1:0] fin_bits;
    logic [PIX_W-1:0] merged;
    logic [PIX_W-1:0] emit_byte;
    logic             packed_fmt;

    // The input register hands its item to the packing logic whenever the
    // output register is empty or being drained this cycle. An item that
    // makes no byte still moves, since it only updates the accumulator.
    assign move    = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall = r_in_vld && !move;

    // Slot selection and bit placement for the current format. The final
    // slot always takes the pixel's top bits in the lowest bits of the byte.
    always_comb begin
        packed_fmt = 1'b1;
        last_slot  = '0;
        mid_bits   = '0;
        fin_bits   = '0;
        case (r_fmt)
            FMT_4BPP: begin
                last_slot = 3'd1;
                mid_bits  = r_in_pixel & MASK_TOP4;
                fin_bits  = r_in_pixel >> 4;
            end
            FMT_3BPP: begin
                // The first slot holds two bits, the next two hold three.
                last_slot = 3'd2;
                mid_bits  = (r_cnt == '0) ? (r_in_pixel & MASK_TOP2)
                                          : ((r_in_pixel & MASK_TOP3) >> 2);
                fin_bits  = r_in_pixel >> 5;
            end
            FMT_2BPP: begin
                last_slot = 3'd3;
                mid_bits  = (r_in_pixel & MASK_TOP2) >> {r_cnt, 1'b0};
                fin_bits  = r_in_pixel >> 6;
            end
            FMT_1BPP: begin
                last_slot = 3'd7;
                mid_bits  = (r_in_pixel & MASK_TOP1) >> r_cnt;
                fin_bits  = r_in_pixel >> 7;
            end
            default: begin
                packed_fmt = 1'b0;
            end
        endcase
    end

    // A fill count at or beyond the format's last slot (possible after a
    // mid-row format change) fills the final slot and completes the byte.
    always_comb begin
        acc_base   = (r_cnt == '0) ? '0 : r_acc;
        final_slot = (r_cnt >= last_slot);
        merged     = acc_base | (final_slot ? fin_bits : mid_bits);
        if (!packed_fmt) begin
            // Eight bits per pixel: the pixel passes straight through and any
            // partial byte left over from another format is dropped.
            emit      = 1'b1;
            emit_byte = r_in_pixel;
            n_acc     = '0;
            n_cnt     = '0;
        end else begin
            emit      = final_slot || r_in_row_end;
            emit_byte = merged;
            n_acc     = emit ? '0 : merged;
            n_cnt     = emit ? '0 : r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_8BPP;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_pixel   <= i_pixel;
            r_in_row_end <= i_row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (move) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move && emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= r_in_row_end;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_packed_byte = r_out_byte;
    assign o_last_of_row = r_out_last;

endmodule

/* rtl/apbp_checker.sv */
// ----------------------------------------------------------------------------
// apbp_checker
// Port-level checks for the alpha pixel bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module apbp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [apbp_pkg::PIX_W-1:0]  o_packed_byte,
    input logic                        o_last_of_row
);
    import apbp_pkg::*;

    // Reset empties the output register.
    a_reset_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Reset empties the input register, so the block cannot stall its source.
    a_reset_no_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // A byte waiting on a stalled sink is neither dropped nor changed.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packed_byte)
                               && $stable(o_last_of_row))
        else $error("stalled output byte changed or dropped");

    // The block only pushes back on its source while the sink stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

bind alpha_pixel_bit_packer_unit apbp_checker u_apbp_checker (.*);

/* tb/tb_alpha_pixel_bit_packer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_pixel_bit_packer_unit
// Self-checking bench for the alpha pixel bit packer. A behavioral model of
// the packing rules runs alongside the block and predicts every packed byte
// from each accepted pixel. A monitor compares each byte the block hands out
// against the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_alpha_pixel_bit_packer_unit;
    import apbp_pkg::*;

    // Codes 5 to 7 have no format of their own and behave as 8 bits per pixel.
    localparam logic [FMT_W-1:0] FMT_SPARE_FIRST = 3'd5;
    localparam logic [FMT_W-1:0] FMT_SPARE_LAST  = 3'd7;

    // The block passes a pixel through its input and output registers, so the
    // drain time after the last expected byte covers pixels that make no byte.
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          END_WAIT      = 2000;
    localparam int unsigned RANDOM_PIXELS = 730;
    localparam int unsigned TIMEOUT_NS    = 4_000_000;

    typedef struct {
        logic [PIX_W-1:0] packed_val;
        logic             row_last;
    } t_packed_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [FMT_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel;
    logic             i_row_end;
    logic             o_valid;
    logic             i_stall;
    logic [PIX_W-1:0] o_packed_byte;
    logic             o_last_of_row;

    // Model state: the format register, the partly filled byte and the
    // number of slots of that byte already taken.
    logic [FMT_W-1:0] fmt_sel      = FMT_8BPP;
    logic [PIX_W-1:0] acc_bits     = '0;
    int unsigned      slots_filled = 0;

    t_packed_result   pending_bytes[$];
    int unsigned      mismatch_count = 0;
    int unsigned      pixels_sent    = 0;
    int unsigned      bytes_checked  = 0;
    int unsigned      format_writes  = 0;
    bit               no_idle        = 1'b0;

    alpha_pixel_bit_packer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .i_row_end     (i_row_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_last_of_row (o_last_of_row)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every idle or stall stretch is drawn here. During a burst phase both
    // sides run flat out so that back-to-back items are exercised as well.
    function automatic int unsigned pick_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Applies one pixel to the model and queues the byte it completes, if any.
    // The slots of a byte are filled from the top; the pixel that lands in the
    // last slot contributes its upper bits to the lowest bits of the byte.
    function automatic void predict_packed(input logic [PIX_W-1:0] px,
                                           input logic             row_last);
        int unsigned      slots;
        logic [PIX_W-1:0] mid_part;
        logic [PIX_W-1:0] low_part;
        bit               emit;

        emit = 1'b0;
        case (fmt_sel)
            FMT_4BPP: begin
                slots    = 2;
                mid_part = px & MASK_TOP4;
                low_part = px >> 4;
            end
            FMT_3BPP: begin
                // The first slot holds only two bits, the other two hold three.
                slots    = 3;
                mid_part = (slots_filled == 0) ? (px & MASK_TOP2) : ((px & MASK_TOP3) >> 2);
                low_part = px >> 5;
            end
            FMT_2BPP: begin
                slots    = 4;
                mid_part = (px & MASK_TOP2) >> (2 * slots_filled);
                low_part = px >> 6;
            end
            FMT_1BPP: begin
                slots    = 8;
                mid_part = (px & MASK_TOP1) >> slots_filled;
                low_part = px >> 7;
            end
            default: begin
                // Full depth and the spare codes pass the pixel through and
                // throw away any partial byte left over from another format.
                acc_bits     = '0;
                slots_filled = 0;
                pending_bytes.push_back('{px, row_last});
                return;
            end
        endcase

        if (slots_filled == 0)
            acc_bits = '0;
        // After a format change in the middle of a row the count may already
        // be past the last slot of the new format; the pixel then closes the
        // byte.
        if (slots_filled >= slots - 1) begin
            acc_bits |= low_part;
            emit = 1'b1;
        end else begin
            acc_bits |= mid_part;
            slots_filled++;
            emit = row_last;
        end

        if (emit) begin
            pending_bytes.push_back('{acc_bits, row_last});
            acc_bits     = '0;
            slots_filled = 0;
        end
    endfunction

    // Offers one pixel after a random gap and holds it until the block takes
    // it. Valid is left high on exit so that a following item with no gap
    // keeps the channel busy without a bubble.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic row_last);
        int unsigned gap;

        gap = pick_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel   <= px;
        i_row_end <= row_last;
        do @(posedge i_clk); while (o_stall);
        predict_packed(px, row_last);
        pixels_sent++;
    endtask

    // Stops sending until every predicted byte has come back, then lets the
    // pipeline run empty for pixels that make no byte.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The format register is only written while the block is idle. The
    // partial byte and the fill count are not touched by the write.
    task automatic write_format(input logic [FMT_W-1:0] code);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        fmt_sel = code;
        format_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // After reset the block must come up in the full depth format.
    task automatic test_reset_format();
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b1);
    endtask

    // A spare code behaves as full depth and drops a partial byte that an
    // earlier format left behind in the same row.
    task automatic test_spare_codes();
        write_format(FMT_4BPP);
        send_pixel(8'hF0, 1'b0);
        for (int c = FMT_SPARE_FIRST; c <= FMT_SPARE_LAST; c++) begin
            write_format(FMT_W'(c));
            send_pixel(8'h5A + 8'(c), (c == FMT_SPARE_LAST));
        end
        // The next packed row must start from an empty byte; its row end
        // flushes a byte with the unused low bits zero.
        write_format(FMT_4BPP);
        send_pixel(8'hAB, 1'b1);
    endtask

    // One complete byte in each packing format, with the row end landing on
    // the pixel that completes the byte in the three and two bit formats.
    task automatic test_packing_formats();
        send_pixel(8'h9F, 1'b0);
        send_pixel(8'h6F, 1'b0);

        write_format(FMT_3BPP);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h1F, 1'b0);
        send_pixel(8'hE0, 1'b1);

        write_format(FMT_2BPP);
        send_pixel(8'h40, 1'b0);
        send_pixel(8'h80, 1'b0);
        send_pixel(8'hC0, 1'b0);
        send_pixel(8'h3F, 1'b1);

        write_format(FMT_1BPP);
        for (int k = 0; k < 8; k++)
            send_pixel((k % 2 == 0) ? 8'h80 : 8'h7F, 1'b0);
    endtask

    // Switching to a format with fewer slots while a byte is partly full: the
    // next pixel goes to the final slot and the byte is handed out at once.
    task automatic test_mid_row_switch();
        write_format(FMT_2BPP);
        send_pixel(8'hC0, 1'b0);
        send_pixel(8'h40, 1'b0);
        send_pixel(8'h80, 1'b0);
        write_format(FMT_4BPP);
        send_pixel(8'hFF, 1'b0);
    endtask

    // Random phases, each under one format. The first eight phases walk all
    // codes, the rest mostly use the packing formats. Most phases send proper
    // rows of random length; a few send row ends at random. Phases do not end
    // on row boundaries, so format changes inside a row happen often.
    task automatic test_random_rows();
        int unsigned      sent;
        int unsigned      row_left;
        int unsigned      phase;
        int unsigned      n;
        logic [FMT_W-1:0] code;
        logic [PIX_W-1:0] px;
        bit               noisy;

        sent     = 0;
        row_left = 0;
        phase    = 0;
        while (sent < RANDOM_PIXELS) begin
            if (phase < 8)
                code = FMT_W'(phase);
            else if ($urandom_range(0, 4) == 0)
                code = FMT_W'($urandom_range(0, 7));
            else
                code = FMT_W'($urandom_range(FMT_4BPP, FMT_1BPP));
            write_format(code);
            noisy   = ($urandom_range(0, 4) == 0);
            no_idle = ($urandom_range(0, 5) == 0);
            n       = $urandom_range(15, 45);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0:       px = 8'h00;
                    1:       px = 8'hFF;
                    default: px = PIX_W'($urandom_range(0, 255));
                endcase
                if (noisy) begin
                    send_pixel(px, ($urandom_range(0, 3) == 0));
                end else begin
                    if (row_left == 0)
                        row_left = $urandom_range(1, 24);
                    send_pixel(px, (row_left == 1));
                    row_left--;
                end
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(0, 40) == 0)
                    wait_idle();
            end
            no_idle = 1'b0;
            sent += n;
            phase++;
        end
    endtask

    // Output side: a fresh stall stretch is drawn for every byte taken.
    initial begin
        int unsigned hold;

        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = pick_wait();
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Each byte the block hands out is checked against the oldest prediction.
    always @(posedge i_clk) begin : check_bytes
        t_packed_result want;

        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last_of_row %0b",
                                          o_packed_byte, o_last_of_row));
            end else begin
                want = pending_bytes.pop_front();
                if (o_packed_byte !== want.packed_val)
                    report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                              o_packed_byte, want.packed_val));
                if (o_last_of_row !== want.row_last)
                    report_mismatch($sformatf("last_of_row %0b, expected %0b",
                                              o_last_of_row, want.row_last));
                bytes_checked++;
            end
        end
    end

    initial begin
        int guard;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = FMT_8BPP;
        i_valid     = 1'b0;
        i_pixel     = '0;
        i_row_end   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_format();
        test_spare_codes();
        test_packing_formats();
        test_mid_row_switch();
        test_random_rows();

        // Let the last bytes come back, with a bound in case some never do.
        i_valid <= 1'b0;
        guard = 0;
        while (pending_bytes.size() != 0 && guard < END_WAIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      pending_bytes.size()));

        $display("Sent %0d pixels and checked %0d packed bytes over %0d format writes,",
                 pixels_sent, bytes_checked, format_writes);
        $display("covering all five formats, the spare codes, row flushes and mid-row switches.");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a block that hangs on either handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d bytes outstanding", pending_bytes.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
